// ===== hdl/sum_checked_frame_receiver_top_assert.svh =====
// Assertion macros for the frame receiver checker.
`ifndef SUM_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SUM_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define SCFR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Next-cycle implication under synchronous reset.
`define SCFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

// ===== hdl/scfr_pkg.sv =====
// Shared types and constants of the sum-checked frame receiver.
`default_nettype none
package scfr_pkg;

    localparam int P_PAYLOAD_MAX = 32;
    localparam int P_KIND_COUNT  = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR2  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LENLO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LENHI = 3'd6;

    localparam logic [8:0] FRAME_OVERHEAD = 9'd8;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_HDR  = 3'd1,
        ST_LEN  = 3'd2,
        ST_SUM  = 3'd3,
        ST_TAIL = 3'd4,
        ST_KIND = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]   hdr1;
        logic [7:0]   hdr2;
        logic [7:0]   tail1;
        logic [7:0]   tail2;
        logic [15:0]  mask;
        logic [127:0] lens;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [7:0] kind;
        logic [7:0] len;
        logic       bank;
    } t_desc;

    typedef struct packed {
        t_status    status;
        logic [7:0] kind;
        logic [7:0] len;
        logic [7:0] pbyte;
        logic       pvalid;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/scfr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module scfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/scfr_front.sv =====
// Front end: byte intake, frame parsing, payload store writes and verdict.
`default_nettype none
module scfr_front #(
    parameter int PAYLOAD_MAX = 32,
    parameter int KIND_COUNT  = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire scfr_pkg::t_cfg                   i_cfg,
    input  wire logic                             i_valid,
    input  wire logic [7:0]                       i_byte,
    input  wire logic                             i_eob,
    output logic                                  o_ready,
    input  wire logic                             i_q_full,
    output logic                                  o_push,
    output scfr_pkg::t_desc                       o_desc,
    output logic                                  o_ram_we,
    output logic [$clog2(2*PAYLOAD_MAX)-1:0]      o_ram_waddr,
    output logic [7:0]                            o_ram_wdata
);
    import scfr_pkg::*;

    localparam int RAW = $clog2(2 * PAYLOAD_MAX);

    logic [7:0]  r_pos, n_pos;
    logic        r_hdr_ok, n_hdr_ok;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_rsum, n_rsum;
    logic        r_tail_ok, n_tail_ok;
    logic        r_bank;

    logic        w_accept;
    logic        w_store;
    logic [8:0]  w_p9;
    logic [8:0]  w_len9;
    logic [7:0]  w_off;
    logic [8:0]  w_waddr9;
    logic [7:0]  w_reg_len;
    logic        w_kind_ok;
    t_status     w_status;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_p9     = {1'b0, r_pos};
    assign w_len9   = {1'b0, r_len};
    assign w_off    = r_pos - 8'd4;

    always_comb begin
        n_hdr_ok  = r_hdr_ok;
        n_kind    = r_kind;
        n_len     = r_len;
        n_sum     = r_sum;
        n_rsum    = r_rsum;
        n_tail_ok = r_tail_ok;
        w_store   = 1'b0;
        priority if (r_pos == 8'd0) begin
            n_hdr_ok = (i_byte == i_cfg.hdr1);
        end else if (r_pos == 8'd1) begin
            n_hdr_ok = r_hdr_ok && (i_byte == i_cfg.hdr2);
        end else if (r_pos == 8'd2) begin
            n_kind = i_byte;
            n_sum  = r_sum + {8'd0, i_byte};
        end else if (r_pos == 8'd3) begin
            n_len = i_byte;
            n_sum = r_sum + {8'd0, i_byte};
        end else if (w_p9 < 9'd4 + w_len9) begin
            w_store = ({1'b0, w_off} < 9'(PAYLOAD_MAX));
            n_sum   = r_sum + {8'd0, i_byte};
        end else if (w_p9 == 9'd4 + w_len9) begin
            n_rsum = {i_byte, r_rsum[7:0]};
        end else if (w_p9 == 9'd5 + w_len9) begin
            n_rsum = {r_rsum[15:8], i_byte};
        end else if (w_p9 == 9'd6 + w_len9) begin
            n_tail_ok = (i_byte == i_cfg.tail1);
        end else if (w_p9 == 9'd7 + w_len9) begin
            n_tail_ok = r_tail_ok && (i_byte == i_cfg.tail2);
        end
        n_pos = (r_pos == 8'd255) ? r_pos : r_pos + 8'd1;
    end

    assign w_reg_len = i_cfg.lens[{n_kind[3:0], 3'b000} +: 8];
    assign w_kind_ok = ({1'b0, n_kind} < 9'(KIND_COUNT)) && i_cfg.mask[n_kind[3:0]]
                       && ({1'b0, w_reg_len} < 9'(PAYLOAD_MAX)) && (w_reg_len == n_len);

    always_comb begin
        priority if (n_pos < 8'd2 || !n_hdr_ok) begin
            w_status = ST_HDR;
        end else if (({1'b0, n_pos} != {1'b0, n_len} + FRAME_OVERHEAD)
                     || ({1'b0, n_len} > 9'(PAYLOAD_MAX))) begin
            w_status = ST_LEN;
        end else if (n_rsum != n_sum) begin
            w_status = ST_SUM;
        end else if (!n_tail_ok) begin
            w_status = ST_TAIL;
        end else if (!w_kind_ok) begin
            w_status = ST_KIND;
        end else begin
            w_status = ST_OK;
        end
    end

    assign o_push = w_accept && i_eob;
    assign o_desc = '{status: w_status, kind: n_kind, len: n_len, bank: r_bank};

    assign w_waddr9    = {1'b0, w_off} + (r_bank ? 9'(PAYLOAD_MAX) : 9'd0);
    assign o_ram_we    = w_accept && w_store;
    assign o_ram_waddr = w_waddr9[RAW-1:0];
    assign o_ram_wdata = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 8'd0;
            r_hdr_ok  <= 1'b1;
            r_kind    <= 8'd0;
            r_len     <= 8'd0;
            r_sum     <= 16'd0;
            r_rsum    <= 16'd0;
            r_tail_ok <= 1'b1;
            r_bank    <= 1'b0;
        end else if (w_accept) begin
            if (i_eob) begin
                r_pos     <= 8'd0;
                r_hdr_ok  <= 1'b1;
                r_kind    <= 8'd0;
                r_len     <= 8'd0;
                r_sum     <= 16'd0;
                r_rsum    <= 16'd0;
                r_tail_ok <= 1'b1;
                r_bank    <= !r_bank;
            end else begin
                r_pos     <= n_pos;
                r_hdr_ok  <= n_hdr_ok;
                r_kind    <= n_kind;
                r_len     <= n_len;
                r_sum     <= n_sum;
                r_rsum    <= n_rsum;
                r_tail_ok <= n_tail_ok;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/scfr_queue.sv =====
// Two-entry verdict queue between front end and back end.
`default_nettype none
module scfr_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire scfr_pkg::t_desc i_desc,
    input  wire logic            i_pop,
    output scfr_pkg::t_desc      o_head,
    output logic                 o_empty,
    output logic                 o_full
);
    import scfr_pkg::*;

    t_desc      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_head  = r_slot[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/scfr_back.sv =====
// Back end: turns verdicts into status results or payload runs.
`default_nettype none
module scfr_back #(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire scfr_pkg::t_desc                  i_head,
    input  wire logic                             i_empty,
    output logic                                  o_pop,
    output logic                                  o_ram_re,
    output logic [$clog2(2*PAYLOAD_MAX)-1:0]      o_ram_raddr,
    input  wire logic [7:0]                       i_ram_rdata,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output scfr_pkg::t_result                     o_result
);
    import scfr_pkg::*;

    localparam int RAW = $clog2(2 * PAYLOAD_MAX);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_READ = 3'b010,
        BK_LOAD = 3'b100
    } t_back_state;

    t_back_state r_state, n_state;
    logic [7:0]  r_idx, n_idx;
    logic        r_valid;
    t_result     r_res, n_res;
    logic        w_free;
    logic        w_load;
    logic        w_last;
    logic [8:0]  w_raddr9;

    assign w_free      = !r_valid || i_ready;
    assign w_last      = (r_idx + 8'd1 == i_head.len);
    assign w_raddr9    = {1'b0, r_idx} + (i_head.bank ? 9'(PAYLOAD_MAX) : 9'd0);
    assign o_ram_raddr = w_raddr9[RAW-1:0];
    assign o_ram_re    = (r_state == BK_READ);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_res   = r_res;
        w_load  = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    if (i_head.status == ST_OK && i_head.len != 8'd0) begin
                        n_idx   = 8'd0;
                        n_state = BK_READ;
                    end else if (w_free) begin
                        n_res  = '{status: i_head.status, kind: i_head.kind,
                                   len: i_head.len, pbyte: 8'd0, pvalid: 1'b0,
                                   last: 1'b1};
                        w_load = 1'b1;
                        o_pop  = 1'b1;
                    end
                end
            end
            BK_READ: begin
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                if (w_free) begin
                    n_res  = '{status: ST_OK, kind: i_head.kind, len: i_head.len,
                               pbyte: i_ram_rdata, pvalid: 1'b1, last: w_last};
                    w_load = 1'b1;
                    if (w_last) begin
                        o_pop   = 1'b1;
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + 8'd1;
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= 8'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;
endmodule
`default_nettype wire

// ===== hdl/sum_checked_frame_receiver_top.sv =====
// Sum-checked frame receiver: top level.
// Slave stream: one received byte per transfer in tdata, tlast on the last
// byte of a buffer. Each buffer is judged as one frame: header, size, byte
// sum, tail, then type enable and registered length.
// Master stream: a good frame gives its payload bytes as a run (tuser high,
// tlast on the last byte); a bad frame, or a good frame with empty payload,
// gives one status transfer with tuser low and tlast high.
// Config channel: register index and data, always ready; write only idle.
// Intake takes one byte per cycle. A verdict enters a two-entry queue on the
// cycle that takes the last byte; intake stalls while two frames are queued,
// since the payload store holds two frames (one bank each).
// Output: a status transfer is loaded from the queue head; each payload byte
// passes a read state and then a load state, and the next read starts only
// after the load, set by the registered read of the payload store.
// A stalled master side holds its transfer in the output register; the front
// end keeps taking bytes until the queue fills.
// Reset (synchronous, active low) clears frame state, queue and output valid
// and loads the register defaults; no clearing pass is needed.
`default_nettype none
module sum_checked_frame_receiver_top #(
    parameter int PAYLOAD_MAX = scfr_pkg::P_PAYLOAD_MAX,
    parameter int KIND_COUNT  = scfr_pkg::P_KIND_COUNT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [7:0]                     i_s_axis_tdata,   // rx_byte[7:0]
    input  wire logic                           i_s_axis_tlast,   // end_of_buffer
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // frame_status[2:0], frame_kind[10:3], declared_length[18:11],
    // payload_byte[26:19], zero fill [31:27]
    output logic [31:0]                         o_m_axis_tdata,
    output logic                                o_m_axis_tuser,   // payload_valid
    output logic                                o_m_axis_tlast,   // run_last
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [scfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                    i_cfg_data
);
    import scfr_pkg::*;

    localparam int RAW = $clog2(2 * PAYLOAD_MAX);

    t_cfg           r_cfg;
    t_desc          w_push_desc;
    t_desc          w_head;
    t_result        w_res;
    logic           w_push;
    logic           w_pop;
    logic           w_empty;
    logic           w_full;
    logic           w_we;
    logic [RAW-1:0] w_waddr;
    logic [7:0]     w_wdata;
    logic           w_re;
    logic [RAW-1:0] w_raddr;
    logic [7:0]     w_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr1  <= 8'hAA;
            r_cfg.hdr2  <= 8'h55;
            r_cfg.tail1 <= 8'h0D;
            r_cfg.tail2 <= 8'h0A;
            r_cfg.mask  <= 16'd0;
            r_cfg.lens  <= 128'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HDR1:  r_cfg.hdr1         <= i_cfg_data[7:0];
                CFG_HDR2:  r_cfg.hdr2         <= i_cfg_data[7:0];
                CFG_TAIL1: r_cfg.tail1        <= i_cfg_data[7:0];
                CFG_TAIL2: r_cfg.tail2        <= i_cfg_data[7:0];
                CFG_MASK:  r_cfg.mask         <= i_cfg_data[15:0];
                CFG_LENLO: r_cfg.lens[63:0]   <= i_cfg_data;
                CFG_LENHI: r_cfg.lens[127:64] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    scfr_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .KIND_COUNT  (KIND_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .i_byte      (i_s_axis_tdata),
        .i_eob       (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_desc      (w_push_desc),
        .o_ram_we    (w_we),
        .o_ram_waddr (w_waddr),
        .o_ram_wdata (w_wdata)
    );

    scfr_ram #(
        .WIDTH (8),
        .DEPTH (2 * PAYLOAD_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    scfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    scfr_back #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_ram_re    (w_re),
        .o_ram_raddr (w_raddr),
        .i_ram_rdata (w_rdata),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (w_res)
    );

    assign o_m_axis_tdata = {5'd0, w_res.pbyte, w_res.len, w_res.kind, w_res.status};
    assign o_m_axis_tuser = w_res.pvalid;
    assign o_m_axis_tlast = w_res.last;
endmodule
`default_nettype wire

// ===== hdl/scfr_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
`default_nettype none
`include "sum_checked_frame_receiver_top_assert.svh"
module scfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser,
    input wire logic        o_m_axis_tlast,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready
);
    import scfr_pkg::*;

    `SCFR_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
        && $stable(o_m_axis_tlast))
    `SCFR_ASSERT_SAME(a_payload_ok, o_m_axis_tvalid && o_m_axis_tuser,
        o_m_axis_tdata[2:0] == ST_OK)
    `SCFR_ASSERT_SAME(a_status_last, o_m_axis_tvalid && !o_m_axis_tuser,
        o_m_axis_tlast && o_m_axis_tdata[26:19] == 8'd0)
    `SCFR_ASSERT_SAME(a_out_fields, o_m_axis_tvalid,
        o_m_axis_tdata[31:27] == 5'd0 && o_m_axis_tdata[2:0] <= ST_KIND)
    `SCFR_ASSERT_SAME(a_cfg_ready, i_cfg_valid, o_cfg_ready)
endmodule

bind sum_checked_frame_receiver_top scfr_checker u_scfr_checker (.*);
`default_nettype wire
